/* rtl/obc_pkg.sv */
// Shared constants, codes and types of the output blink controller.
package obc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int TICK_BITS  = 16;
   localparam int CMP_BITS   = (TIMER_BITS > TICK_BITS) ? TIMER_BITS : TICK_BITS;
   localparam int LEVEL_BITS = 8;
   localparam int FUNC_BITS  = 3;
   localparam int MODE_BITS  = 3;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0] ON_LEVEL_RESET = 8'd255;

   localparam logic [FUNC_BITS-1:0] FUNC_TICK        = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_OFF         = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_ON          = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_SET_VALUE   = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_BLINK       = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_BLINK_BREAK = 3'd5;

   localparam logic [MODE_BITS-1:0] MODE_OFF   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ON    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_HOLD  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_BLINK = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_BREAK = 3'd4;

   typedef struct packed {
      logic [MODE_BITS-1:0]  run_mode;
      logic [LEVEL_BITS-1:0] drive_value;
      logic [LEVEL_BITS-1:0] reported_value;
      logic [7:0]            pulses_done;
      logic [7:0]            pulses_wanted;
      logic [TICK_BITS-1:0]  toggle_interval;
      logic [TICK_BITS-1:0]  pause_interval;
      logic [TIMER_BITS-1:0] toggle_elapsed;
      logic [TIMER_BITS-1:0] pause_elapsed;
   } obc_state_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] port_value;
      logic                  changed;
      logic [MODE_BITS-1:0]  cur_mode;
   } obc_result_type;

endpackage

/* rtl/obc_core.sv */
// Next-state and result logic for one item of the output blink controller.
module obc_core (
   input  obc_pkg::obc_state_type          cur,
   input  logic [obc_pkg::LEVEL_BITS-1:0]  on_level,
   input  logic [obc_pkg::FUNC_BITS-1:0]   func,
   input  logic [obc_pkg::LEVEL_BITS-1:0]  level,
   input  logic [7:0]                      blink_count,
   input  logic [obc_pkg::TICK_BITS-1:0]   blink_ticks,
   input  logic [obc_pkg::TICK_BITS-1:0]   pause_ticks,
   output obc_pkg::obc_state_type          nxt,
   output obc_pkg::obc_result_type         result
);
   import obc_pkg::*;

   logic [TIMER_BITS-1:0] t_adv;
   logic [TIMER_BITS-1:0] p_adv;
   logic                  t_exp;
   logic                  p_exp;
   logic                  can_toggle;
   logic                  same_break;

   assign t_adv = (cur.toggle_elapsed == TIMER_MAX) ? TIMER_MAX
                                                     : cur.toggle_elapsed + 1'b1;
   assign p_adv = (cur.pause_elapsed == TIMER_MAX) ? TIMER_MAX
                                                    : cur.pause_elapsed + 1'b1;
   assign t_exp = CMP_BITS'(t_adv) >= CMP_BITS'(cur.toggle_interval);
   assign p_exp = CMP_BITS'(p_adv) >= CMP_BITS'(cur.pause_interval);
   assign can_toggle = cur.pulses_done < cur.pulses_wanted;
   assign same_break = (cur.run_mode == MODE_BREAK) && (cur.pulses_wanted == blink_count) &&
                       (cur.toggle_interval == blink_ticks) &&
                       (cur.pause_interval == pause_ticks);

   always_comb begin
      nxt = cur;
      case (func)
         FUNC_TICK: begin
            nxt.toggle_elapsed = t_adv;
            nxt.pause_elapsed  = p_adv;
            case (cur.run_mode)
               MODE_OFF:  nxt.drive_value = '0;
               MODE_ON:   nxt.drive_value = on_level;
               MODE_HOLD: nxt.drive_value = cur.drive_value;
               MODE_BLINK: begin
                  if (t_exp) begin
                     if (can_toggle) begin
                        if (cur.drive_value == '0) begin
                           nxt.drive_value = on_level;
                           nxt.pulses_done = cur.pulses_done + 8'd1;
                        end else begin
                           nxt.drive_value = '0;
                        end
                        nxt.toggle_elapsed = '0;
                     end else begin
                        nxt.run_mode = MODE_OFF;
                     end
                  end
               end
               MODE_BREAK: begin
                  if (p_exp && t_exp) begin
                     if (can_toggle) begin
                        if (cur.drive_value == '0) begin
                           nxt.drive_value = on_level;
                           nxt.pulses_done = cur.pulses_done + 8'd1;
                        end else begin
                           nxt.drive_value = '0;
                        end
                     end else begin
                        nxt.drive_value   = '0;
                        nxt.pause_elapsed = '0;
                        nxt.pulses_done   = '0;
                     end
                     nxt.toggle_elapsed = '0;
                  end
               end
               default: nxt.run_mode = MODE_OFF;
            endcase
         end
         FUNC_OFF: nxt.run_mode = MODE_OFF;
         FUNC_ON:  nxt.run_mode = MODE_ON;
         FUNC_SET_VALUE: begin
            nxt.drive_value = level;
            nxt.run_mode    = MODE_HOLD;
         end
         FUNC_BLINK: begin
            nxt.pulses_wanted   = blink_count;
            nxt.toggle_interval = blink_ticks;
            nxt.toggle_elapsed  = TIMER_MAX;
            nxt.pulses_done     = '0;
            nxt.run_mode        = MODE_BLINK;
         end
         FUNC_BLINK_BREAK: begin
            if (!same_break) begin
               nxt.pulses_wanted   = blink_count;
               nxt.toggle_interval = blink_ticks;
               nxt.toggle_elapsed  = TIMER_MAX;
               nxt.pause_interval  = pause_ticks;
               nxt.pause_elapsed   = TIMER_MAX;
               nxt.pulses_done     = '0;
            end
            nxt.run_mode = MODE_BREAK;
         end
         default: nxt = cur;
      endcase
      result.port_value  = nxt.drive_value;
      result.changed     = nxt.drive_value != cur.reported_value;
      result.cur_mode    = nxt.run_mode;
      nxt.reported_value = nxt.drive_value;
   end

endmodule

/* rtl/output_blink_controller.sv */
// Top level of the output blink controller: state, result register and handshakes.
//
//   Channel  Direction  Handshake             Carries
//   req      in         req_valid/req_ready   func, level, blink_count, blink_ticks, pause_ticks
//   rsp      out        rsp_valid/rsp_ready   port_value, changed, cur_mode
//   csr      in         csr_valid/csr_ready   on_level write data
//
// A transferred request gives its response in the next cycle; one per cycle unless rsp stalls.
// The state update and the response are formed in a single pass of the core logic.
// Requests are taken while the response register is empty or being drained.
// Reset sets on_level to 255 and clears state and rsp_valid only; csr writes are always taken.
module output_blink_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [obc_pkg::FUNC_BITS-1:0]   req_func,
   input  logic [obc_pkg::LEVEL_BITS-1:0]  req_level,
   input  logic [7:0]                      req_blink_count,
   input  logic [obc_pkg::TICK_BITS-1:0]   req_blink_ticks,
   input  logic [obc_pkg::TICK_BITS-1:0]   req_pause_ticks,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [obc_pkg::LEVEL_BITS-1:0]  rsp_port_value,
   output logic                            rsp_changed,
   output logic [obc_pkg::MODE_BITS-1:0]   rsp_cur_mode,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [obc_pkg::LEVEL_BITS-1:0]  csr_on_level
);
   import obc_pkg::*;

   obc_state_type         state_ff;
   obc_state_type         state_in;
   obc_result_type        result_ff;
   obc_result_type        result_in;
   logic                  rsp_valid_ff;
   logic [LEVEL_BITS-1:0] on_level_ff;
   logic                  req_xfer;

   obc_core u_core (
      .cur         (state_ff),
      .on_level    (on_level_ff),
      .func        (req_func),
      .level       (req_level),
      .blink_count (req_blink_count),
      .blink_ticks (req_blink_ticks),
      .pause_ticks (req_pause_ticks),
      .nxt         (state_in),
      .result      (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         on_level_ff  <= ON_LEVEL_RESET;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (req_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            on_level_ff <= csr_on_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_port_value = result_ff.port_value;
   assign rsp_changed    = result_ff.changed;
   assign rsp_cur_mode   = result_ff.cur_mode;

endmodule

/* rtl/obc_checker.sv */
// Port-level assertions for the output blink controller and their binding.
module obc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [obc_pkg::FUNC_BITS-1:0]   req_func,
   input logic [obc_pkg::LEVEL_BITS-1:0]  req_level,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [obc_pkg::LEVEL_BITS-1:0]  rsp_port_value,
   input logic [obc_pkg::MODE_BITS-1:0]   rsp_cur_mode
);
   import obc_pkg::*;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_req_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer without a response");

   a_rsp_drains : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response repeated without a request");

   a_set_value : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_SET_VALUE |=>
      rsp_port_value == $past(req_level) && rsp_cur_mode == MODE_HOLD)
      else $error("set value response does not hold the requested level");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_port_value))
      else $error("stalled response changed");

endmodule

bind output_blink_controller obc_checker u_obc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_func       (req_func),
   .req_level      (req_level),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_port_value (rsp_port_value),
   .rsp_cur_mode   (rsp_cur_mode)
);

/* tb/tb_top.sv */
// Self-checking testbench for the output blink controller: directed table, then random phases.
module tb_top;
   import obc_pkg::*;

   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_HI = 3'd7;
   localparam int ROW_COUNT = 27;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 146;
   localparam int LONG_HOLD_CYCLES = 60;

   typedef enum {RX_ALWAYS, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} rx_style_type;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [LEVEL_BITS-1:0] level;
      logic [7:0]            count;
      logic [TICK_BITS-1:0]  bticks;
      logic [TICK_BITS-1:0]  pticks;
      logic                  typed;
      obc_result_type        want;
   } blink_cmd_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [FUNC_BITS-1:0] req_func;
   logic [LEVEL_BITS-1:0] req_level;
   logic [7:0] req_blink_count;
   logic [TICK_BITS-1:0] req_blink_ticks;
   logic [TICK_BITS-1:0] req_pause_ticks;
   logic rsp_valid;
   logic rsp_ready;
   logic [LEVEL_BITS-1:0] rsp_port_value;
   logic rsp_changed;
   logic [MODE_BITS-1:0] rsp_cur_mode;
   logic csr_valid;
   logic csr_ready;
   logic [LEVEL_BITS-1:0] csr_on_level;

   output_blink_controller dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_level(req_level),
      .req_blink_count(req_blink_count),
      .req_blink_ticks(req_blink_ticks),
      .req_pause_ticks(req_pause_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_port_value(rsp_port_value),
      .rsp_changed(rsp_changed),
      .rsp_cur_mode(rsp_cur_mode),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_on_level(csr_on_level)
   );

   logic [LEVEL_BITS-1:0] active_on_level;
   logic [MODE_BITS-1:0]  blink_mode;
   logic [LEVEL_BITS-1:0] port_level;
   logic [LEVEL_BITS-1:0] last_reported;
   logic [7:0]            pulse_count;
   logic [7:0]            pulse_target;
   logic [TICK_BITS-1:0]  toggle_gap;
   logic [TICK_BITS-1:0]  pause_gap;
   logic [TIMER_BITS-1:0] toggle_age;
   logic [TIMER_BITS-1:0] pause_age;

   obc_result_type pending_port_results[$];
   blink_cmd_type offered_cmd;
   blink_cmd_type last_break;
   bit have_break;
   bit hold_request;
   int unsigned burst_left;
   int unsigned mismatch_count;

   blink_cmd_type directed_rows [0:ROW_COUNT-1] = '{
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_ON,          8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_ON}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hFF, 1'b1, MODE_ON}},
      '{FUNC_SET_VALUE,   8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b1, MODE_HOLD}},
      '{FUNC_SET_VALUE,   8'hFF, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hFF, 1'b1, MODE_HOLD}},
      '{FUNC_SET_VALUE,   8'hA5, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hA5, 1'b1, MODE_HOLD}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hA5, 1'b0, MODE_HOLD}},
      '{FUNC_OFF,         8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hA5, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b1, MODE_OFF}},
      '{FUNC_SPARE_LO,    8'hFF, 8'd255, 16'hFFFF,  16'hFFFF,  1'b1, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_SPARE_HI,    8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_BLINK,       8'h00, 8'd2,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_BLINK}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hFF, 1'b1, MODE_BLINK}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b1, MODE_BLINK}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hFF, 1'b1, MODE_BLINK}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'hFF, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b1, MODE_OFF}},
      '{FUNC_BLINK,       8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_BLINK}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b1, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_BLINK,       8'h00, 8'd255, 16'hFFFF,  16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_BLINK_BREAK, 8'h00, 8'd1,   16'd1,     16'hFFFF,  1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_BLINK_BREAK, 8'h00, 8'd1,   16'd1,     16'hFFFF,  1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_BLINK_BREAK, 8'h00, 8'd0,   16'd0,     16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}},
      '{FUNC_TICK,        8'h00, 8'd0,   16'd0,     16'd0,     1'b0, '{8'h00, 1'b0, MODE_OFF}}
   };

   function automatic bit advance_pulse();
      if (pulse_count < pulse_target) begin
         if (port_level == '0) begin
            port_level = active_on_level;
            pulse_count = pulse_count + 8'd1;
         end else begin
            port_level = '0;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic apply_blink_command(input blink_cmd_type c, output obc_result_type r);
      case (c.func)
         FUNC_TICK: begin
            if (toggle_age != TIMER_MAX) toggle_age = toggle_age + 1'b1;
            if (pause_age != TIMER_MAX) pause_age = pause_age + 1'b1;
            case (blink_mode)
               MODE_OFF: port_level = '0;
               MODE_ON: port_level = active_on_level;
               MODE_HOLD: ;
               MODE_BLINK: begin
                  if (toggle_age >= toggle_gap) begin
                     if (advance_pulse()) toggle_age = '0;
                     else blink_mode = MODE_OFF;
                  end
               end
               MODE_BREAK: begin
                  if (pause_age >= pause_gap && toggle_age >= toggle_gap) begin
                     if (!advance_pulse()) begin
                        port_level = '0;
                        pause_age = '0;
                        pulse_count = '0;
                     end
                     toggle_age = '0;
                  end
               end
               default: blink_mode = MODE_OFF;
            endcase
         end
         FUNC_OFF: blink_mode = MODE_OFF;
         FUNC_ON: blink_mode = MODE_ON;
         FUNC_SET_VALUE: begin
            port_level = c.level;
            blink_mode = MODE_HOLD;
         end
         FUNC_BLINK: begin
            pulse_target = c.count;
            toggle_gap = c.bticks;
            toggle_age = TIMER_MAX;
            pulse_count = '0;
            blink_mode = MODE_BLINK;
         end
         FUNC_BLINK_BREAK: begin
            if (!(blink_mode == MODE_BREAK && pulse_target == c.count &&
                  toggle_gap == c.bticks && pause_gap == c.pticks)) begin
               pulse_target = c.count;
               toggle_gap = c.bticks;
               toggle_age = TIMER_MAX;
               pause_gap = c.pticks;
               pause_age = TIMER_MAX;
               pulse_count = '0;
            end
            blink_mode = MODE_BREAK;
         end
         default: ;
      endcase
      r.port_value = port_level;
      r.changed = (port_level != last_reported);
      r.cur_mode = blink_mode;
      last_reported = port_level;
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin : watch_ports
      blink_cmd_type seen;
      obc_result_type want;
      obc_result_type predicted;
      if (reset) begin
         active_on_level = ON_LEVEL_RESET;
         blink_mode = MODE_OFF;
         port_level = '0;
         last_reported = '0;
         pulse_count = '0;
         pulse_target = '0;
         toggle_gap = '0;
         pause_gap = '0;
         toggle_age = '0;
         pause_age = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_port_results.size() == 0) begin
               flag_mismatch("unexpected transfer", rsp_port_value, 0);
            end else begin
               want = pending_port_results.pop_front();
               if (rsp_port_value !== want.port_value)
                  flag_mismatch("port_value", rsp_port_value, want.port_value);
               if (rsp_changed !== want.changed)
                  flag_mismatch("changed", rsp_changed, want.changed);
               if (rsp_cur_mode !== want.cur_mode)
                  flag_mismatch("cur_mode", rsp_cur_mode, want.cur_mode);
            end
         end
         if (req_valid && req_ready) begin
            seen = offered_cmd;
            seen.func = req_func;
            seen.level = req_level;
            seen.count = req_blink_count;
            seen.bticks = req_blink_ticks;
            seen.pticks = req_pause_ticks;
            apply_blink_command(seen, predicted);
            pending_port_results.push_back(seen.typed ? seen.want : predicted);
         end
         if (csr_valid && csr_ready) active_on_level = csr_on_level;
      end
   end

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      rx_style_type style;
      int unsigned style_left;
      int unsigned hold_left;
      bit hold_taken;
      rsp_ready = 1'b0;
      style = RX_ALWAYS;
      style_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(8, 80);
            end
            style_left--;
            case (style)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               RX_EVERY_THIRD: rsp_ready <= (style_left % 3) != 0;
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send(input blink_cmd_type c);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      offered_cmd = c;
      req_valid <= 1'b1;
      req_func <= c.func;
      req_level <= c.level;
      req_blink_count <= c.count;
      req_blink_ticks <= c.bticks;
      req_pause_ticks <= c.pticks;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_port_results.size() != 0);
   endtask

   task automatic write_on_level(input logic [LEVEL_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_on_level <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic blink_cmd_type random_fields();
      blink_cmd_type c;
      c = '0;
      c.level = LEVEL_BITS'($urandom_range(0, 255));
      c.count = 8'($urandom_range(0, 255));
      c.bticks = TICK_BITS'($urandom_range(0, 65535));
      c.pticks = TICK_BITS'($urandom_range(0, 65535));
      return c;
   endfunction

   function automatic logic [TICK_BITS-1:0] extreme_ticks();
      int unsigned pick;
      pick = $urandom_range(0, 2);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return TICK_BITS'($urandom_range(0, 65535));
   endfunction

   task automatic random_phase(input int unsigned quota);
      blink_cmd_type c;
      int unsigned sent;
      int unsigned pick;
      int unsigned ticks;
      sent = 0;
      while (sent < quota) begin
         c = random_fields();
         pick = $urandom_range(0, 15);
         if (pick < 2) begin
            c.func = FUNC_BITS'($urandom_range(0, 7));
         end else if (pick == 2) begin
            c.func = FUNC_OFF;
         end else if (pick == 3) begin
            c.func = FUNC_ON;
         end else if (pick < 6) begin
            c.func = FUNC_SET_VALUE;
         end else begin
            if (pick < 10 || (pick == 15 && $urandom_range(0, 1) == 0))
               c.func = FUNC_BLINK;
            else
               c.func = FUNC_BLINK_BREAK;
            if (pick == 15) begin
               c.bticks = extreme_ticks();
               c.pticks = extreme_ticks();
            end else begin
               c.count = 8'($urandom_range(0, 4));
               c.bticks = TICK_BITS'($urandom_range(0, 3));
               c.pticks = TICK_BITS'($urandom_range(0, 6));
               if (c.func == FUNC_BLINK_BREAK && have_break && $urandom_range(0, 2) == 0) begin
                  c.count = last_break.count;
                  c.bticks = last_break.bticks;
                  c.pticks = last_break.pticks;
               end
            end
            if (c.func == FUNC_BLINK_BREAK) begin
               last_break = c;
               have_break = 1'b1;
            end
         end
         send(c);
         sent++;
         ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 10);
         repeat (ticks) begin
            c = random_fields();
            c.func = FUNC_TICK;
            send(c);
            sent++;
         end
      end
   endtask

   initial begin
      logic [LEVEL_BITS-1:0] level_plan [0:PHASE_COUNT-1];
      int row;
      int phase;
      level_plan = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'hFF};
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_level = '0;
      req_blink_count = '0;
      req_blink_ticks = '0;
      req_pause_ticks = '0;
      csr_valid = 1'b0;
      csr_on_level = '0;
      offered_cmd = '0;
      last_break = '0;
      have_break = 1'b0;
      hold_request = 1'b0;
      burst_left = 0;
      mismatch_count = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < ROW_COUNT; row++) send(directed_rows[row]);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         if (phase == 3 || phase == 4) level_plan[phase] = LEVEL_BITS'($urandom_range(0, 255));
         write_on_level(level_plan[phase]);
         if (phase == 2) hold_request = 1'b1;
         random_phase(PHASE_ITEMS);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
